// File: rtl/core/mpsg_pkg.sv
package mpsg_pkg;

  // Largest supported mode count, which is also the qubit count
  localparam int unsigned MaxModes = 64;
  localparam int unsigned QubitW   = $clog2(MaxModes);
  localparam int unsigned CountW   = QubitW + 1;
  localparam int unsigned IndexW   = CountW;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MODE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAPPING    = 2'd1;

  // Mapping select codes; the unused code behaves as Jordan-Wigner
  localparam logic [1:0] MAP_JW     = 2'd0;
  localparam logic [1:0] MAP_PARITY = 2'd1;
  localparam logic [1:0] MAP_BK     = 2'd2;

  // Pauli factor codes
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_X    = 2'd1,
    OP_Y    = 2'd2,
    OP_Z    = 2'd3
  } pauli_e;

  // One qubit lookup for the operator unit
  typedef struct packed {
    logic [1:0]        mapping;
    logic [QubitW-1:0] mode;
    logic              odd;
    logic [QubitW-1:0] qubit;
  } op_req_t;

endpackage

// File: rtl/core/mpsg_op_unit.sv
module mpsg_op_unit (
  input  mpsg_pkg::op_req_t req_i,
  output mpsg_pkg::pauli_e  op_o
);
  import mpsg_pkg::*;

  logic [QubitW-1:0] j;
  logic [QubitW-1:0] q;
  logic [QubitW:0]   q_inc;
  logic              par_hit;
  logic              par_keep;
  logic              upd_hit;

  assign j     = req_i.mode;
  assign q     = req_i.qubit;
  assign q_inc = {1'b0, q} + {{QubitW{1'b0}}, 1'b1};

  // Bravyi-Kitaev tree membership, one independent check per tree level b.
  // Parity node at level b: j[b] set, q shares j above b, q[b:0] = 0 then ones.
  // Update node at level b: j[b] clear, q shares j above b, q[b:0] all ones.
  always_comb begin
    logic [QubitW-1:0] lo_mask;
    logic [QubitW-1:0] par_pat;
    logic              hi_eq;
    logic              flip;
    par_hit  = 1'b0;
    par_keep = 1'b0;
    upd_hit  = 1'b0;
    for (int b = 0; b < QubitW; b++) begin
      lo_mask = QubitW'((1 << (b + 1)) - 1);
      par_pat = QubitW'((1 << b) - 1);
      hi_eq   = ((q & ~lo_mask) == (j & ~lo_mask));
      flip    = ((j & lo_mask) == lo_mask);
      if (j[b] && hi_eq && ((q & lo_mask) == par_pat)) begin
        par_hit = 1'b1;
        if (!(req_i.odd && flip)) begin
          par_keep = 1'b1;
        end
      end
      if (!j[b] && hi_eq && ((q & lo_mask) == lo_mask)) begin
        upd_hit = 1'b1;
      end
    end
  end

  // Factor on this qubit for the selected mapping
  always_comb begin
    op_o = OP_NONE;
    case (req_i.mapping)
      MAP_PARITY: begin
        if (q == j) begin
          op_o = req_i.odd ? OP_Y : OP_X;
        end else if (q > j) begin
          op_o = OP_X;
        end else if (!req_i.odd && (q_inc == {1'b0, j})) begin
          op_o = OP_Z;
        end
      end
      MAP_BK: begin
        if (q == j) begin
          op_o = req_i.odd ? OP_Y : OP_X;
        end else if (par_hit && par_keep) begin
          op_o = OP_Z;
        end else if (upd_hit) begin
          op_o = OP_X;
        end
      end
      default: begin
        if (q == j) begin
          op_o = req_i.odd ? OP_Y : OP_X;
        end else if (q < j) begin
          op_o = OP_Z;
        end
      end
    endcase
  end

endmodule

// File: rtl/core/majorana_pauli_string_generator_top.sv
// Majorana Pauli string generator: one command scans qubits 0..n-1, n the mode count,
// one qubit a cycle through a shared operator unit, then flushes the held entry.
// A new command is taken only when the block is idle again.
// Entries trail discovery by the held slot, and the receiver cannot stall.
// An out-of-range index answers next cycle, never busy.
// Reset (rst_ni low, asynchronous) idles the block, mode count 1, Jordan-Wigner.
module majorana_pauli_string_generator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command
  input  logic                           start,
  output logic                           busy,
  input  logic [mpsg_pkg::IndexW-1:0]    majorana_index_i,
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mpsg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mpsg_pkg::CountW-1:0]    cfg_data_i,
  // results
  output logic                           result_valid_o,
  output logic [mpsg_pkg::QubitW-1:0]    qubit_index_o,
  output logic [1:0]                     pauli_op_o,
  output logic                           last_entry_o,
  output logic                           range_error_o
);
  import mpsg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // Configuration registers
  logic [CountW-1:0] mode_count_q;
  logic [1:0]        mapping_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= CountW'(1);
      mapping_q    <= MAP_JW;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE_COUNT: mode_count_q <= cfg_data_i;
        CFG_MAPPING:    mapping_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Effective mode count, saturated
  logic [CountW-1:0] nm;
  logic              range_err;

  assign nm        = (mode_count_q > CountW'(MaxModes)) ? CountW'(MaxModes) : mode_count_q;
  assign range_err = {1'b0, majorana_index_i} >= {nm, 1'b0};

  // Sequencer registers
  state_e            state_q, state_d;
  logic [QubitW-1:0] qubit_q, qubit_d;
  logic [QubitW-1:0] mode_q, mode_d;
  logic              odd_q, odd_d;
  logic              pend_vld_q, pend_vld_d;
  logic [QubitW-1:0] pend_qubit_q, pend_qubit_d;
  pauli_e            pend_op_q, pend_op_d;
  logic              res_vld_q, res_vld_d;
  logic [QubitW-1:0] res_qubit_q, res_qubit_d;
  pauli_e            res_op_q, res_op_d;
  logic              res_last_q, res_last_d;
  logic              res_err_q, res_err_d;

  // Shared operator unit
  op_req_t unit_req;
  pauli_e  unit_op;
  logic    scan_end;

  assign unit_req.mapping = mapping_q;
  assign unit_req.mode    = mode_q;
  assign unit_req.odd     = odd_q;
  assign unit_req.qubit   = qubit_q;

  mpsg_op_unit u_op_unit (
    .req_i (unit_req),
    .op_o  (unit_op)
  );

  assign scan_end = ({1'b0, qubit_q} == (nm - CountW'(1)));
  assign busy     = (state_q != ST_IDLE);

  // Next-state logic; one held entry gives the lookahead for the last mark
  always_comb begin
    state_d      = state_q;
    qubit_d      = qubit_q;
    mode_d       = mode_q;
    odd_d        = odd_q;
    pend_vld_d   = pend_vld_q;
    pend_qubit_d = pend_qubit_q;
    pend_op_d    = pend_op_q;
    res_vld_d    = 1'b0;
    res_qubit_d  = res_qubit_q;
    res_op_d     = res_op_q;
    res_last_d   = res_last_q;
    res_err_d    = res_err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (range_err) begin
            res_vld_d   = 1'b1;
            res_qubit_d = '0;
            res_op_d    = OP_NONE;
            res_last_d  = 1'b1;
            res_err_d   = 1'b1;
          end else begin
            state_d    = ST_SCAN;
            qubit_d    = '0;
            mode_d     = majorana_index_i[IndexW-1:1];
            odd_d      = majorana_index_i[0];
            pend_vld_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (unit_op != OP_NONE) begin
          if (pend_vld_q) begin
            res_vld_d   = 1'b1;
            res_qubit_d = pend_qubit_q;
            res_op_d    = pend_op_q;
            res_last_d  = 1'b0;
            res_err_d   = 1'b0;
          end
          pend_vld_d   = 1'b1;
          pend_qubit_d = qubit_q;
          pend_op_d    = unit_op;
        end
        if (scan_end) begin
          state_d = ST_FLUSH;
        end else begin
          qubit_d = qubit_q + QubitW'(1);
        end
      end
      ST_FLUSH: begin
        res_vld_d   = 1'b1;
        res_qubit_d = pend_qubit_q;
        res_op_d    = pend_op_q;
        res_last_d  = 1'b1;
        res_err_d   = 1'b0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      qubit_q      <= '0;
      mode_q       <= '0;
      odd_q        <= 1'b0;
      pend_vld_q   <= 1'b0;
      pend_qubit_q <= '0;
      pend_op_q    <= OP_NONE;
      res_vld_q    <= 1'b0;
      res_qubit_q  <= '0;
      res_op_q     <= OP_NONE;
      res_last_q   <= 1'b0;
      res_err_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      qubit_q      <= qubit_d;
      mode_q       <= mode_d;
      odd_q        <= odd_d;
      pend_vld_q   <= pend_vld_d;
      pend_qubit_q <= pend_qubit_d;
      pend_op_q    <= pend_op_d;
      res_vld_q    <= res_vld_d;
      res_qubit_q  <= res_qubit_d;
      res_op_q     <= res_op_d;
      res_last_q   <= res_last_d;
      res_err_q    <= res_err_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign qubit_index_o  = res_qubit_q;
  assign pauli_op_o     = res_op_q;
  assign last_entry_o   = res_last_q;
  assign range_error_o  = res_err_q;

`ifndef SYNTHESIS
  // error beat is a lone, terminal, op-less entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && range_error_o |-> last_entry_o && (pauli_op_o == OP_NONE))
    else $error("error beat malformed");

  // every normal beat carries a real factor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !range_error_o |-> (pauli_op_o != OP_NONE))
    else $error("normal beat without a factor");

  // out-of-range command answers next cycle and does not go busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && range_err |=> result_valid_o && range_error_o && !busy)
    else $error("missing error beat");

  // flush always ends the string with a marked beat and idles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |=> result_valid_o && last_entry_o && !busy)
    else $error("string not terminated");

  // a scan always holds an entry by the time it flushes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> pend_vld_q)
    else $error("flush with no held entry");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mpsg_pkg::*;

  // Register indexes past the end of the list; writes to them must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int unsigned        CycleLimit   = 400000;
  localparam int unsigned        DirRows      = 24;

  // One Pauli factor as it leaves the block
  typedef struct packed {
    logic [QubitW-1:0] qubit;
    pauli_e            op;
    logic              last;
    logic              err;
  } term_t;

  // Directed stimulus: setting, index, and a hand-written term where it is obvious
  typedef struct packed {
    logic [CountW-1:0] modes;
    logic [1:0]        mapping;
    logic [IndexW-1:0] index;
    logic              fixed;
    term_t             want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                start            = 1'b0;
  logic                busy;
  logic [IndexW-1:0]   majorana_index_i = '0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CountW-1:0]   cfg_data_i       = '0;
  logic                result_valid_o;
  logic [QubitW-1:0]   qubit_index_o;
  logic [1:0]          pauli_op_o;
  logic                last_entry_o;
  logic                range_error_o;

  // Mirror of the configuration registers
  logic [CountW-1:0]   mode_reg = CountW'(1);
  logic [1:0]          map_reg  = MAP_JW;

  term_t       pending_terms[$];
  int unsigned idle_pct;
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned terms_seen;
  int unsigned settings_done;
  int unsigned cycles;
  dir_row_t    dir_rows[DirRows];

  majorana_pauli_string_generator_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .majorana_index_i (majorana_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .qubit_index_o    (qubit_index_o),
    .pauli_op_o       (pauli_op_o),
    .last_entry_o     (last_entry_o),
    .range_error_o    (range_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Append one expected term to the scoreboard
  function automatic void queue_term(input term_t t);
    pending_terms.insert(pending_terms.size(), t);
  endfunction

  // Expected Pauli string for one Majorana index under the mirrored setting
  function automatic void predict_terms(input logic [IndexW-1:0] m);
    int unsigned nm, j, tree, n, off, jj, half, q, last_q;
    bit          odd;
    pauli_e      ops[MaxModes];
    bit          par[MaxModes];
    bit          flp[MaxModes];
    term_t       t;
    nm = mode_reg;
    if (nm > MaxModes) nm = MaxModes;
    if (int'(m) >= 2 * nm) begin
      t = '{qubit: '0, op: OP_NONE, last: 1'b1, err: 1'b1};
      queue_term(t);
      return;
    end
    j   = m >> 1;
    odd = m[0];
    for (q = 0; q < MaxModes; q++) begin
      ops[q] = OP_NONE;
      par[q] = 1'b0;
      flp[q] = 1'b0;
    end
    case (map_reg)
      MAP_PARITY: begin
        if (odd) begin
          ops[j] = OP_Y;
          for (q = j + 1; q < nm; q++) ops[q] = OP_X;
        end else begin
          if (j > 0) ops[j-1] = OP_Z;
          for (q = j; q < nm; q++) ops[q] = OP_X;
        end
      end
      MAP_BK: begin
        tree = 1;
        while (tree < nm) tree <<= 1;
        // parity and flip sets: left siblings met on the way down
        n = tree; off = 0; jj = j;
        while (n > 1) begin
          half = n >> 1;
          if (jj < half) begin
            n = half;
          end else begin
            q = off + half - 1;
            if (q < nm) begin
              par[q] = 1'b1;
              if (jj >= n - 1) flp[q] = 1'b1;
            end
            jj -= half; off += half; n = half;
          end
        end
        // update set: roots of subtrees that j sits in the left half of
        n = tree; off = 0; jj = j;
        while (n > 1) begin
          half = n >> 1;
          if (jj < half) begin
            if (off + n - 1 < nm) ops[off+n-1] = OP_X;
            n = half;
          end else begin
            jj -= half; off += half; n = half;
          end
        end
        for (q = 0; q < nm; q++)
          if (par[q] && !(odd && flp[q])) ops[q] = OP_Z;
        ops[j] = odd ? OP_Y : OP_X;
      end
      // Jordan-Wigner, and the unused code too
      default: begin
        for (q = 0; q < j; q++) ops[q] = OP_Z;
        ops[j] = odd ? OP_Y : OP_X;
      end
    endcase
    last_q = 0;
    for (q = 0; q < nm; q++)
      if (ops[q] != OP_NONE) last_q = q;
    for (q = 0; q < nm; q++) begin
      if (ops[q] != OP_NONE) begin
        t = '{qubit: QubitW'(q), op: ops[q], last: (q == last_q), err: 1'b0};
        queue_term(t);
      end
    end
  endfunction

  // One command beat; start stays high on return
  task automatic send_item(input logic [IndexW-1:0] m, input bit fixed, input term_t want);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    majorana_index_i <= m;
    do @(posedge clk_i); while (busy);
    if (fixed) queue_term(want);
    else predict_terms(m);
    items_sent++;
  endtask

  // One config beat; valid stays high on return
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MODE_COUNT) mode_reg = data;
    else if (idx == CFG_MAPPING) map_reg = data[1:0];
  endtask

  // Let the block go idle, then rewrite both registers plus a spare index
  task automatic apply_setting(input logic [CountW-1:0] mc, input logic [1:0] mp);
    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_write(CFG_MODE_COUNT, mc);
    cfg_write(CFG_MAPPING, {(CountW-2)'($urandom_range(31)), mp});
    cfg_write($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CountW'($urandom_range(127)));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_done++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    term_t t;
    if (rst_ni && result_valid_o) begin
      terms_seen++;
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected result q=%0d op=%0d last=%0b err=%0b", $time,
                 qubit_index_o, pauli_op_o, last_entry_o, range_error_o);
        err_count++;
      end else begin
        t = pending_terms.pop_front();
        if (qubit_index_o !== t.qubit) begin
          $display("%0t: qubit_index expected %0d got %0d", $time, t.qubit, qubit_index_o);
          err_count++;
        end
        if (pauli_op_o !== t.op) begin
          $display("%0t: pauli_op expected %0d got %0d", $time, t.op, pauli_op_o);
          err_count++;
        end
        if (last_entry_o !== t.last) begin
          $display("%0t: last_entry expected %0b got %0b", $time, t.last, last_entry_o);
          err_count++;
        end
        if (range_error_o !== t.err) begin
          $display("%0t: range_error expected %0b got %0b", $time, t.err, range_error_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_terms.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned nm, ph, s, k;
    logic [CountW-1:0] mc;
    term_t none_t;
    none_t = '0;
    // mode_count, mapping, index, fixed, hand-written term
    dir_rows = '{
      // reset setting: one mode, Jordan-Wigner
      '{7'd1,   MAP_JW,     7'd0,   1'b1, '{6'd0,  OP_X,    1'b1, 1'b0}},
      '{7'd1,   MAP_JW,     7'd1,   1'b1, '{6'd0,  OP_Y,    1'b1, 1'b0}},
      '{7'd1,   MAP_JW,     7'd2,   1'b1, '{6'd0,  OP_NONE, 1'b1, 1'b1}},
      '{7'd1,   MAP_JW,     7'd127, 1'b1, '{6'd0,  OP_NONE, 1'b1, 1'b1}},
      // zero modes: everything out of range
      '{7'd0,   MAP_JW,     7'd0,   1'b1, '{6'd0,  OP_NONE, 1'b1, 1'b1}},
      '{7'd64,  MAP_JW,     7'd0,   1'b1, '{6'd0,  OP_X,    1'b1, 1'b0}},
      '{7'd64,  MAP_JW,     7'd127, 1'b0, '0},
      '{7'd64,  MAP_JW,     7'd126, 1'b0, '0},
      // mode count above the maximum saturates
      '{7'd127, MAP_PARITY, 7'd0,   1'b0, '0},
      '{7'd127, MAP_PARITY, 7'd127, 1'b1, '{6'd63, OP_Y,    1'b1, 1'b0}},
      '{7'd5,   MAP_PARITY, 7'd4,   1'b0, '0},
      '{7'd5,   MAP_PARITY, 7'd10,  1'b1, '{6'd0,  OP_NONE, 1'b1, 1'b1}},
      '{7'd5,   MAP_PARITY, 7'd9,   1'b1, '{6'd4,  OP_Y,    1'b1, 1'b0}},
      '{7'd8,   MAP_BK,     7'd0,   1'b0, '0},
      '{7'd8,   MAP_BK,     7'd1,   1'b0, '0},
      '{7'd8,   MAP_BK,     7'd7,   1'b0, '0},
      '{7'd8,   MAP_BK,     7'd14,  1'b0, '0},
      '{7'd8,   MAP_BK,     7'd15,  1'b0, '0},
      // tree wider than the mode count
      '{7'd6,   MAP_BK,     7'd9,   1'b0, '0},
      '{7'd6,   MAP_BK,     7'd11,  1'b0, '0},
      // unused selector code
      '{7'd3,   2'd3,       7'd4,   1'b0, '0},
      '{7'd3,   2'd3,       7'd5,   1'b0, '0},
      '{7'd64,  MAP_BK,     7'd0,   1'b0, '0},
      '{7'd64,  MAP_BK,     7'd127, 1'b0, '0}
    };
    err_count = 0; items_sent = 0; terms_seen = 0; settings_done = 0; cycles = 0;
    idle_pct = 11;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; registers rewritten only when the setting changes
    for (k = 0; k < DirRows; k++) begin
      if (dir_rows[k].modes != mode_reg || dir_rows[k].mapping != map_reg)
        apply_setting(dir_rows[k].modes, dir_rows[k].mapping);
      send_item(dir_rows[k].index, dir_rows[k].fixed, dir_rows[k].want);
    end

    // random part: three idling phases, several settings each
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 11 : (ph == 1) ? 55 : 0;
      for (s = 0; s < 4; s++) begin
        k = $urandom_range(99);
        if (k < 5)       mc = 7'd0;
        else if (k < 12) mc = 7'd64;
        else if (k < 17) mc = CountW'($urandom_range(127, 65));
        else if (k < 30) mc = CountW'($urandom_range(63, 9));
        else             mc = CountW'($urandom_range(8, 1));
        apply_setting(mc, 2'($urandom_range(3)));
        nm = (mode_reg > MaxModes) ? MaxModes : mode_reg;
        for (k = 0; k < 21; k++) begin
          if (nm > 0 && $urandom_range(99) < 85)
            send_item(IndexW'($urandom_range(2 * nm - 1)), 1'b0, none_t);
          else
            send_item(IndexW'($urandom_range(127)), 1'b0, none_t);
        end
      end
    end

    // drain and allow for a straggler
    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Sent %0d Majorana indexes over %0d register settings; checked %0d Pauli terms.",
             items_sent, settings_done, terms_seen);
    $display("Mappings JW, parity, BK and the spare code; mode counts 0 to 127; %0d mismatches.",
             err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
